// ===== hdl/btgr_pkg.sv =====
// Shared types and constants for the bitmap text glyph renderer.
// No dependencies; imported by every module of the block.
package btgr_pkg;

    localparam int STORE_AW     = 12;
    localparam int STORE_DEPTH  = 1 << STORE_AW;
    localparam int ROW_W        = 8;
    localparam int ADDR_W       = 37;
    localparam int COLOR_W      = 32;
    localparam int CUR_W        = 16;
    localparam int BASE_W       = 32;
    localparam int STRIDE_W     = 3;
    localparam int PITCH_W      = 16;
    localparam int CODE_W       = 8;
    localparam int GLYPH_W_LOG2 = 3;   // glyphs are eight pixels wide

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // configuration register numbers (paddr[3:2])
    localparam logic [1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [1:0] REG_PIXEL_STRIDE = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH    = 2'd2;

    localparam logic [BASE_W-1:0]   FRAME_BASE_RST   = 32'd0;
    localparam logic [STRIDE_W-1:0] PIXEL_STRIDE_RST = 3'd1;
    localparam logic [PITCH_W-1:0]  ROW_PITCH_RST    = 16'd1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XY,
        ST_MUL,
        ST_ADD,
        ST_ROW
    } t_state;

    // operation select for the shared address adder
    typedef struct packed {
        logic load_x;   // acc = base + column offset, also line * height
        logic mul_y;    // y product = line rows * pitch
        logic add_y;    // acc += y product
        logic step;     // acc += pitch, next glyph row
    } t_addr_ctl;

endpackage

// ===== hdl/btgr_glyph_store.sv =====
// Glyph row store: one write port, one read port with registered data.
// Depends on btgr_pkg.
module btgr_glyph_store
    import btgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [STORE_AW-1:0] i_wr_idx,
    input  logic [ROW_W-1:0]    i_wr_data,
    input  logic                i_rd_en,
    input  logic [STORE_AW-1:0] i_rd_idx,
    output logic [ROW_W-1:0]    o_rd_data
);

    logic [ROW_W-1:0] r_mem [STORE_DEPTH];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // read data holds while the output side is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/btgr_addr_unit.sv =====
// Row address unit: one shared 37-bit adder plus the two cursor multipliers.
// Depends on btgr_pkg.
module btgr_addr_unit
    import btgr_pkg::*;
#(
    parameter int GLYPH_HEIGHT = 16
)
(
    input  logic                i_clk,
    input  t_addr_ctl           i_ctl,
    input  logic [BASE_W-1:0]   i_frame_base,
    input  logic [STRIDE_W-1:0] i_pixel_stride,
    input  logic [PITCH_W-1:0]  i_row_pitch,
    input  logic [CUR_W-1:0]    i_col,
    input  logic [CUR_W-1:0]    i_line,
    output logic [ADDR_W-1:0]   o_row_address
);

    localparam int YW = CUR_W + $clog2(GLYPH_HEIGHT + 1);
    localparam int PW = YW + PITCH_W;
    localparam int XW = CUR_W + STRIDE_W;

    logic [YW-1:0]     r_ylin;
    logic [ADDR_W-1:0] r_yprod;
    logic [ADDR_W-1:0] r_acc;

    logic [XW-1:0]     xprod;
    logic [PW-1:0]     yprod;
    logic [ADDR_W-1:0] op_a;
    logic [ADDR_W-1:0] op_b;
    logic [ADDR_W-1:0] sum;

    assign xprod = XW'(i_col) * XW'(i_pixel_stride);
    assign yprod = PW'(r_ylin) * PW'(i_row_pitch);

    always_comb begin
        op_a = r_acc;
        op_b = ADDR_W'(i_row_pitch);
        if (i_ctl.load_x) begin
            op_a = ADDR_W'(i_frame_base);
            op_b = ADDR_W'({xprod, {GLYPH_W_LOG2{1'b0}}});
        end else if (i_ctl.add_y) begin
            op_b = r_yprod;
        end
    end

    assign sum = op_a + op_b;   // wraps mod 2^37

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_x) begin
            r_ylin <= YW'(i_line) * YW'(GLYPH_HEIGHT);
        end
        if (i_ctl.mul_y) begin
            r_yprod <= ADDR_W'(yprod);
        end
        if (i_ctl.load_x || i_ctl.add_y || i_ctl.step) begin
            r_acc <= sum;
        end
    end

    assign o_row_address = r_acc;

endmodule

// ===== hdl/bitmap_text_glyph_renderer_unit.sv =====
// Top level of the bitmap text glyph renderer: sequencer, cursor, config port.
// Depends on btgr_pkg, btgr_glyph_store and btgr_addr_unit.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | action, char_code, pixel_color,
//          |           |                            | glyph_row_index, glyph_row_bits
//  out     | source    | o_out_valid / i_out_stall  | row_address, row_mask, out_color,
//          |           |                            | last_row
//  cfg     | APB slave | psel / penable / pready    | paddr[3:0], pwdata, prdata (32 bits)
//
// A load beat or a newline is taken in ST_IDLE and leaves the block ready again.
// A drawn character first runs the setup states ST_XY, ST_MUL and ST_ADD on the
// shared adder and multipliers, then moves one glyph row per cycle out of the
// single store read port while the out channel does not stall.
// The in channel is stalled for the whole of a character; the output register
// lets the next beat in while the final row still waits.
// Reset (i_rst_n low, synchronous) clears cursor, sequencer, output valid and
// config registers; the glyph store holds garbage until rows are loaded.
module bitmap_text_glyph_renderer_unit
    import btgr_pkg::*;
#(
    parameter int GLYPH_HEIGHT = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic [CODE_W-1:0]   i_char_code,
    input  logic [COLOR_W-1:0]  i_pixel_color,
    input  logic [STORE_AW-1:0] i_glyph_row_index,
    input  logic [ROW_W-1:0]    i_glyph_row_bits,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [ADDR_W-1:0]   o_row_address,
    output logic [ROW_W-1:0]    o_row_mask,
    output logic [COLOR_W-1:0]  o_out_color,
    output logic                o_last_row,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int RW = $clog2(GLYPH_HEIGHT);
    localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_HEIGHT - 1);

    // config registers
    logic [BASE_W-1:0]   r_frame_base;
    logic [STRIDE_W-1:0] r_pixel_stride;
    logic [PITCH_W-1:0]  r_row_pitch;

    // sequencer and cursor
    t_state              r_state;
    t_state              n_state;
    logic [CUR_W-1:0]    r_col;
    logic [CUR_W-1:0]    r_line;
    logic [RW-1:0]       r_row;
    logic [CODE_W-1:0]   r_code;
    logic [COLOR_W-1:0]  r_color;

    // output register
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_row_address;
    logic [ROW_W-1:0]    r_row_mask;
    logic [COLOR_W-1:0]  r_out_color;
    logic                r_last_row;

    logic                in_stall;
    logic                in_acc;
    logic                is_draw;
    logic                is_newline;
    logic                row_last;
    logic                adv;
    logic                rd_en;
    logic [RW-1:0]       rd_row;
    logic [STORE_AW-1:0] rd_idx;
    logic [ROW_W-1:0]    rd_data;
    logic [ADDR_W-1:0]   acc_addr;
    t_addr_ctl           addr_ctl;
    logic                cfg_wr;

    // ------------------------------------------------------------------
    // Config port: zero wait states, reads are plain muxes
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base   <= FRAME_BASE_RST;
            r_pixel_stride <= PIXEL_STRIDE_RST;
            r_row_pitch    <= ROW_PITCH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FRAME_BASE:   r_frame_base   <= pwdata[BASE_W-1:0];
                REG_PIXEL_STRIDE: r_pixel_stride <= pwdata[STRIDE_W-1:0];
                REG_ROW_PITCH:    r_row_pitch    <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_BASE:   prdata = 32'(r_frame_base);
            REG_PIXEL_STRIDE: prdata = 32'(r_pixel_stride);
            REG_ROW_PITCH:    prdata = 32'(r_row_pitch);
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Beat decode
    // ------------------------------------------------------------------
    assign in_acc     = i_in_valid && !in_stall;
    assign is_newline = (i_action == ACT_PUT) && (i_char_code == NEWLINE_CODE);
    assign is_draw    = (i_action == ACT_PUT) && (i_char_code != NEWLINE_CODE);
    assign row_last   = (r_row == LAST_ROW);
    // a row moves into the output register whenever that register is free
    assign adv        = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_draw) begin
                    n_state = ST_XY;
                end
            end
            ST_XY:   n_state = ST_MUL;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_ROW;
            ST_ROW: begin
                if (adv && row_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        in_stall = 1'b1;
        addr_ctl = '0;
        rd_en    = 1'b0;
        rd_row   = r_row + RW'(1);
        unique case (r_state)
            ST_IDLE: in_stall = 1'b0;
            ST_XY:   addr_ctl.load_x = 1'b1;
            ST_MUL:  addr_ctl.mul_y = 1'b1;
            ST_ADD: begin
                addr_ctl.add_y = 1'b1;
                rd_en          = 1'b1;   // fetch top row
                rd_row         = '0;
            end
            ST_ROW: begin
                addr_ctl.step = adv && !row_last;
                rd_en         = adv && !row_last;
            end
            default: ;
        endcase
    end

    assign o_in_stall = in_stall;

    // store entry = code * height + row, wrapped to the store size
    assign rd_idx = STORE_AW'(32'(r_code) * GLYPH_HEIGHT) + STORE_AW'(rd_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_line  <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc && is_newline) begin
                r_col  <= '0;
                r_line <= r_line + CUR_W'(1);
            end else if (r_state == ST_ROW && adv && row_last) begin
                r_col <= r_col + CUR_W'(1);
            end
            if (r_state == ST_ADD) begin
                r_row <= '0;
            end else if (r_state == ST_ROW && adv && !row_last) begin
                r_row <= r_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code  <= i_char_code;
            r_color <= i_pixel_color;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_ROW && adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROW && adv) begin
            r_row_address <= acc_addr;
            r_row_mask    <= rd_data;
            r_out_color   <= r_color;
            r_last_row    <= row_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_address = r_row_address;
    assign o_row_mask    = r_row_mask;
    assign o_out_color   = r_out_color;
    assign o_last_row    = r_last_row;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    btgr_glyph_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && (i_action == ACT_LOAD)),
        .i_wr_idx  (i_glyph_row_index),
        .i_wr_data (i_glyph_row_bits),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    btgr_addr_unit #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_addr (
        .i_clk          (i_clk),
        .i_ctl          (addr_ctl),
        .i_frame_base   (r_frame_base),
        .i_pixel_stride (r_pixel_stride),
        .i_row_pitch    (r_row_pitch),
        .i_col          (r_col),
        .i_line         (r_line),
        .o_row_address  (acc_addr)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // a row taken into the output register is presented on the next cycle
    a_row_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW && adv) |=> o_out_valid)
        else $error("row beat not presented");

    // leaving the row phase means the final row has just been loaded
    a_last_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_ROW && r_state == ST_IDLE) |-> (o_out_valid && o_last_row))
        else $error("character finished without last row");

    // row counter stays inside the glyph
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= LAST_ROW)
        else $error("row counter out of range");

    // column only changes on a newline or at the end of a character
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROW && !(in_acc && is_newline)) |=> $stable(r_col))
        else $error("unexpected column change");
`endif

endmodule
